[rtl/cgd_pkg.sv]
`default_nettype none
package cgd_pkg;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PENDING  = 3'd1,
        PH_ALLOWED  = 3'd2,
        PH_DENIED   = 3'd3,
        PH_EXPIRED  = 3'd4,
        PH_CONSUMED = 3'd5
    } phase_t;

    typedef enum logic [3:0] {
        ST_READY       = 4'd0,
        ST_REQUIRED    = 4'd1,
        ST_BUSY        = 4'd2,
        ST_DENIED      = 4'd3,
        ST_EXPIRED     = 4'd4,
        ST_MISMATCH    = 4'd5,
        ST_CONSUMED    = 4'd6,
        ST_MISSING     = 4'd7,
        ST_NOT_ALLOWED = 4'd8
    } status_t;

    localparam logic [2:0] OP_PREPARE  = 3'd0;
    localparam logic [2:0] OP_CONSUME  = 3'd1;
    localparam logic [2:0] OP_ALLOW    = 3'd2;
    localparam logic [2:0] OP_DENY     = 3'd3;
    localparam logic [2:0] OP_POLL     = 3'd4;
    localparam logic [2:0] OP_SNAPSHOT = 3'd5;

    localparam logic [1:0] CFG_PENDING_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_ALLOWED_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_TERM_RETENTION   = 2'd2;

    localparam logic [30:0] PENDING_TIMEOUT_RST = 31'd60000;
    localparam logic [30:0] ALLOWED_TIMEOUT_RST = 31'd60000;
    localparam logic [30:0] TERM_RETENTION_RST  = 31'd10000;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        has_id;
        logic [31:0] request_id;
        logic [31:0] request_size;
        logic [31:0] time_now;
    } cmd_t;

    typedef struct packed {
        logic [30:0] pending_timeout;
        logic [30:0] allowed_timeout;
        logic [30:0] terminal_retention;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] next_id;
        logic [31:0] current_id;
        logic [31:0] current_size;
        logic [31:0] created_time;
        logic [31:0] pending_until;
        logic [31:0] allowed_until;
        logic [31:0] block_until;
        logic        terminal_seen;
        phase_t      record_phase;
        logic [31:0] record_id;
        logic [31:0] record_size;
        logic [31:0] record_until;
    } gate_st_t;

    typedef struct packed {
        status_t     status;
        logic        success;
        logic [31:0] answer_id;
    } res_t;

    // Deadline counts as reached when (now - dl) is non-negative modulo 2^32
    function automatic logic reached(input logic [31:0] now, input logic [31:0] dl);
        logic [31:0] diff;
        diff = now - dl;
        return ~diff[31];
    endfunction

endpackage
`default_nettype wire

[rtl/cgd_cfg.sv]
`default_nettype none
module cgd_cfg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output cgd_pkg::cfg_t      cfg_o
);

    cgd_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg_o  = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pending_timeout    <= cgd_pkg::PENDING_TIMEOUT_RST;
            cfg_reg.allowed_timeout    <= cgd_pkg::ALLOWED_TIMEOUT_RST;
            cfg_reg.terminal_retention <= cgd_pkg::TERM_RETENTION_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                cgd_pkg::CFG_PENDING_TIMEOUT: cfg_reg.pending_timeout    <= pwdata[30:0];
                cgd_pkg::CFG_ALLOWED_TIMEOUT: cfg_reg.allowed_timeout    <= pwdata[30:0];
                cgd_pkg::CFG_TERM_RETENTION:  cfg_reg.terminal_retention <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            cgd_pkg::CFG_PENDING_TIMEOUT: prdata = {1'b0, cfg_reg.pending_timeout};
            cgd_pkg::CFG_ALLOWED_TIMEOUT: prdata = {1'b0, cfg_reg.allowed_timeout};
            cgd_pkg::CFG_TERM_RETENTION:  prdata = {1'b0, cfg_reg.terminal_retention};
            default:                      prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/cgd_exec.sv]
`default_nettype none
module cgd_exec (
    input  cgd_pkg::cmd_t     cmd_i,
    input  cgd_pkg::cfg_t     cfg_i,
    input  cgd_pkg::gate_st_t st_i,
    output cgd_pkg::gate_st_t st_o,
    output cgd_pkg::res_t     res_o
);

    cgd_pkg::gate_st_t s1;
    logic              op_live;
    logic              expired;
    logic [31:0]       now;
    logic [31:0]       block_dl;
    logic [31:0]       record_dl;
    logic [31:0]       pend_dl;
    logic [31:0]       allow_dl;
    logic              cur_match;
    logic              rec_match;
    logic              inactive;
    logic              s1_terminal;
    cgd_pkg::status_t  rec_status;
    logic [31:0]       nid;
    logic [31:0]       nid_inc;

    assign now       = cmd_i.time_now;
    assign op_live   = (cmd_i.opcode <= cgd_pkg::OP_POLL);
    assign block_dl  = now + {1'b0, cfg_i.terminal_retention};
    assign record_dl = now + {1'b0, cfg_i.pending_timeout};
    assign pend_dl   = record_dl;
    assign allow_dl  = now + {1'b0, cfg_i.allowed_timeout};

    // Expire a pending or allowed request whose deadline has been reached (not on snapshot or unused codes)
    always_comb begin
        s1      = st_i;
        expired = 1'b0;
        if (op_live &&
            ((st_i.phase == cgd_pkg::PH_PENDING &&
              cgd_pkg::reached(now, st_i.pending_until)) ||
             (st_i.phase == cgd_pkg::PH_ALLOWED &&
              cgd_pkg::reached(now, st_i.allowed_until)))) begin
            expired          = 1'b1;
            s1.phase         = cgd_pkg::PH_EXPIRED;
            s1.allowed_until = '0;
            s1.block_until   = block_dl;
            s1.terminal_seen = 1'b0;
            s1.record_phase  = cgd_pkg::PH_EXPIRED;
            s1.record_id     = st_i.current_id;
            s1.record_size   = st_i.current_size;
            s1.record_until  = record_dl;
        end
    end

    assign s1_terminal = (s1.phase == cgd_pkg::PH_DENIED) ||
                         (s1.phase == cgd_pkg::PH_EXPIRED);
    assign cur_match   = (s1.current_id != '0) && (cmd_i.request_id == s1.current_id) &&
                         (cmd_i.request_size == s1.current_size);
    assign rec_match   = ((s1.record_phase == cgd_pkg::PH_DENIED) ||
                          (s1.record_phase == cgd_pkg::PH_EXPIRED)) &&
                         !cgd_pkg::reached(now, s1.record_until) &&
                         (s1.record_id != '0) && (cmd_i.request_id == s1.record_id) &&
                         (cmd_i.request_size == s1.record_size);
    assign rec_status  = (s1.record_phase == cgd_pkg::PH_DENIED) ?
                         cgd_pkg::ST_DENIED : cgd_pkg::ST_EXPIRED;
    assign inactive    = (s1.phase == cgd_pkg::PH_IDLE) ||
                         (s1.phase == cgd_pkg::PH_CONSUMED) ||
                         (s1_terminal &&
                          (s1.terminal_seen || cgd_pkg::reached(now, s1.block_until)));
    assign nid         = (s1.next_id == '0) ? 32'd1 : s1.next_id;
    assign nid_inc     = nid + 32'd1;

    always_comb begin
        st_o            = s1;
        res_o.status    = cgd_pkg::ST_READY;
        res_o.success   = 1'b0;
        res_o.answer_id = '0;
        unique case (cmd_i.opcode)
            cgd_pkg::OP_PREPARE: begin
                res_o.answer_id = s1.current_id;
                if (!cmd_i.has_id) begin
                    if (inactive) begin
                        st_o.phase         = cgd_pkg::PH_PENDING;
                        st_o.current_id    = nid;
                        st_o.next_id       = (nid_inc == '0) ? 32'd1 : nid_inc;
                        st_o.current_size  = cmd_i.request_size;
                        st_o.created_time  = now;
                        st_o.pending_until = pend_dl;
                        st_o.allowed_until = '0;
                        st_o.block_until   = '0;
                        st_o.terminal_seen = 1'b0;
                        res_o.status       = cgd_pkg::ST_REQUIRED;
                        res_o.answer_id    = nid;
                    end else begin
                        res_o.status = cgd_pkg::ST_BUSY;
                    end
                end else if (!cur_match) begin
                    if (rec_match) begin
                        res_o.answer_id = cmd_i.request_id;
                        res_o.status    = rec_status;
                    end else begin
                        res_o.status = cgd_pkg::ST_MISMATCH;
                    end
                end else if (s1.phase == cgd_pkg::PH_PENDING) begin
                    res_o.status = cgd_pkg::ST_REQUIRED;
                end else if (s1.phase == cgd_pkg::PH_ALLOWED) begin
                    res_o.status = cgd_pkg::ST_READY;
                end else begin
                    res_o.status = (s1.phase == cgd_pkg::PH_DENIED) ?
                                   cgd_pkg::ST_DENIED : cgd_pkg::ST_EXPIRED;
                    if (s1_terminal) begin
                        st_o.terminal_seen = 1'b1;
                        st_o.block_until   = '0;
                    end
                end
            end
            cgd_pkg::OP_CONSUME: begin
                if (!cmd_i.has_id) begin
                    res_o.answer_id = s1.current_id;
                    res_o.status    = cgd_pkg::ST_MISSING;
                end else begin
                    res_o.answer_id = cmd_i.request_id;
                    if (!cur_match) begin
                        res_o.status = rec_match ? rec_status : cgd_pkg::ST_MISMATCH;
                    end else if (s1.phase == cgd_pkg::PH_ALLOWED) begin
                        st_o.phase         = cgd_pkg::PH_CONSUMED;
                        st_o.allowed_until = '0;
                        st_o.block_until   = '0;
                        st_o.terminal_seen = 1'b0;
                        res_o.status       = cgd_pkg::ST_CONSUMED;
                    end else if (s1.phase == cgd_pkg::PH_PENDING) begin
                        res_o.status = cgd_pkg::ST_NOT_ALLOWED;
                    end else begin
                        res_o.status = (s1.phase == cgd_pkg::PH_DENIED) ?
                                       cgd_pkg::ST_DENIED : cgd_pkg::ST_EXPIRED;
                        if (s1_terminal) begin
                            st_o.terminal_seen = 1'b1;
                            st_o.block_until   = '0;
                        end
                    end
                end
            end
            cgd_pkg::OP_ALLOW: begin
                if (s1.phase == cgd_pkg::PH_PENDING) begin
                    st_o.phase         = cgd_pkg::PH_ALLOWED;
                    st_o.allowed_until = allow_dl;
                    st_o.block_until   = '0;
                    st_o.terminal_seen = 1'b0;
                    res_o.success      = 1'b1;
                end
            end
            cgd_pkg::OP_DENY: begin
                if (s1.phase == cgd_pkg::PH_PENDING) begin
                    st_o.phase         = cgd_pkg::PH_DENIED;
                    st_o.allowed_until = '0;
                    st_o.block_until   = block_dl;
                    st_o.terminal_seen = 1'b0;
                    st_o.record_phase  = cgd_pkg::PH_DENIED;
                    st_o.record_id     = s1.current_id;
                    st_o.record_size   = s1.current_size;
                    st_o.record_until  = record_dl;
                    res_o.success      = 1'b1;
                end
            end
            cgd_pkg::OP_POLL: res_o.success = expired;
            // snapshot and unused codes report the state unchanged
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[rtl/confirm_gate_with_deadlines_core.sv]
// An accepted command waits in the input register; its result is registered onto m_*.
// Throughput: one command per cycle; the input register refills while the result register
// drains, and a stalled result holds only the command queued behind it.
// Reset: synchronous, active low; gate state and timeouts return to their reset values,
// both channel stages are emptied.
`default_nettype none
module confirm_gate_with_deadlines_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // tdata: request_id[31:0], request_size[63:32], time_now[95:64]
    input  wire logic [95:0]   s_tdata,
    // tuser: opcode[2:0], has_id[3]
    input  wire logic [3:0]    s_tuser,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // tdata: status[3:0], success[4], answer_id[36:5], phase_now[39:37], held_id[71:40],
    // held_size[103:72], created_at[135:104], pending_deadline[167:136],
    // allowed_deadline[199:168]
    output logic [199:0]       m_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready
);

    cgd_pkg::cfg_t     cfg;
    cgd_pkg::cmd_t     cmd_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic [199:0]      out_data_reg;
    cgd_pkg::gate_st_t state_reg;
    cgd_pkg::gate_st_t state_next;
    cgd_pkg::res_t     res;
    logic              advance;

    cgd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_o   (cfg)
    );

    cgd_exec u_exec (
        .cmd_i (cmd_reg),
        .cfg_i (cfg),
        .st_i  (state_reg),
        .st_o  (state_next),
        .res_o (res)
    );

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg.phase         <= cgd_pkg::PH_IDLE;
            state_reg.next_id       <= 32'd1;
            state_reg.current_id    <= '0;
            state_reg.current_size  <= '0;
            state_reg.created_time  <= '0;
            state_reg.pending_until <= '0;
            state_reg.allowed_until <= '0;
            state_reg.block_until   <= '0;
            state_reg.terminal_seen <= 1'b0;
            state_reg.record_phase  <= cgd_pkg::PH_IDLE;
            state_reg.record_id     <= '0;
            state_reg.record_size   <= '0;
            state_reg.record_until  <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg.opcode       <= s_tuser[2:0];
            cmd_reg.has_id       <= s_tuser[3];
            cmd_reg.request_id   <= s_tdata[31:0];
            cmd_reg.request_size <= s_tdata[63:32];
            cmd_reg.time_now     <= s_tdata[95:64];
        end
        if (advance) begin
            out_data_reg <= {state_next.allowed_until, state_next.pending_until,
                             state_next.created_time, state_next.current_size,
                             state_next.current_id, state_next.phase,
                             res.answer_id, res.success, res.status};
        end
    end

    a_result_after_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("result register not loaded after a command was executed");

    a_state_only_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("gate state changed without an executed command");

    a_next_id_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.next_id != '0)
        else $error("next ID counter reached zero");

    a_consumed_no_deadline: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == cgd_pkg::PH_CONSUMED |-> state_reg.allowed_until == '0)
        else $error("consumed request still carries an allowed deadline");

endmodule
`default_nettype wire
